// ===== hw/rtl/enm_pkg.sv =====
// Shared types and constants for the enveloped note mixer.
// Used by enveloped_note_mixer_core; depends on nothing else.
package enm_pkg;

    // Field widths of the sample path and the register file
    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 32;
    localparam int INV_LEN_W = 25;
    localparam int AMP_W     = 15;
    localparam int ENV_W     = 17;   // Q1.16, 1.0 = 65536
    localparam int MUL_W     = 32;   // operand width of the shared multiplier

    // APB register map: register index is paddr[3:2]
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_INV_LEN   = 2'd1;
    localparam logic [1:0] REG_AMPLITUDE = 2'd2;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'd3000;

    // Envelope constants (Q.16)
    localparam logic [ENV_W-1:0] ENV_ONE          = 17'd65536;
    localparam logic [ENV_W-1:0] ENV_EIGHT_TENTHS = 17'd52429;
    localparam logic [ENV_W-1:0] ENV_TWO_TENTHS   = 17'd13107;

    // Sine evaluation constants (Q.30)
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Sequencer: one multiplication per step from ST_INDEX to ST_AMP through the shared unit
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_FRAC,
        ST_ENV,
        ST_SCALE,
        ST_AMP,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/enveloped_note_mixer_core.sv =====
// Enveloped note mixer, built on enm_pkg. A new input sample is taken only in IDLE, so
// each sample is finished before another is accepted; the single shared 32x32 multiplier
// is stepped by the sequencer through five products (index, fraction, envelope,
// envelope scaling, amplitude scaling); DONE does the saturating add and waits on the output.
// Reset (i_rst_n low, synchronous) clears phase, note position, sequencer and
// output valid, and loads registers to increment 0, inverse length 0, amp 3000.
module enveloped_note_mixer_core #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int POSITION_WIDTH   = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [enm_pkg::SAMPLE_W-1:0] i_existing_sample,
    input  logic                                i_first_of_note,
    // output sample channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [enm_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic                                o_clipped,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [enm_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int FRAC_W = POSITION_WIDTH + enm_pkg::INV_LEN_W;
    localparam int SW     = enm_pkg::SAMPLE_W;

    // ------------------------------------------------------------------
    // Sine table, built at elaboration. Each entry is the Taylor series up
    // to x^11 in Q.30, folded by quadrant, rounded to Q1.15.
    // ------------------------------------------------------------------
    typedef logic signed [SW-1:0] t_sine_rom [SINE_TABLE_DEPTH];

    function automatic logic signed [SW-1:0] sine_value(input int idx);
        longint unsigned a, r, x, x2, t1, t2, t3, t4, t5, s_pos, s_neg, val;
        logic [1:0] quad;
        a    = (longint'(idx) << 32) / SINE_TABLE_DEPTH;
        quad = a[31:30];
        r    = a & (enm_pkg::Q30_ONE - 64'd1);
        if (quad[0]) begin
            r = enm_pkg::Q30_ONE - r;
        end
        x     = (r * enm_pkg::HALF_PI_Q30) >> 30;
        x2    = (x * x) >> 30;
        t1    = ((x  * x2) >> 30) / 6;
        t2    = ((t1 * x2) >> 30) / 20;
        t3    = ((t2 * x2) >> 30) / 42;
        t4    = ((t3 * x2) >> 30) / 72;
        t5    = ((t4 * x2) >> 30) / 110;
        s_pos = x + t2 + t4;
        s_neg = t1 + t3 + t5;
        val   = (s_pos > s_neg) ? s_pos - s_neg : 64'd0;
        val   = (val * 64'd32767 + (enm_pkg::Q30_ONE >> 1)) >> 30;
        if (val > 64'd32767) begin
            val = 64'd32767;
        end
        return quad[1] ? -SW'(val) : SW'(val);
    endfunction

    function automatic t_sine_rom build_rom();
        t_sine_rom rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine_value(i);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [enm_pkg::PHASE_W-1:0]   r_phase_inc;
    logic [enm_pkg::INV_LEN_W-1:0] r_inv_len;
    logic [enm_pkg::AMP_W-1:0]     r_amplitude;
    logic                          w_cfg_write;
    logic [1:0]                    w_reg_idx;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[3:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_inv_len   <= '0;
            r_amplitude <= enm_pkg::AMP_RESET;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                enm_pkg::REG_PHASE_INC: r_phase_inc <= pwdata;
                enm_pkg::REG_INV_LEN:   r_inv_len   <= pwdata[enm_pkg::INV_LEN_W-1:0];
                enm_pkg::REG_AMPLITUDE: r_amplitude <= pwdata[enm_pkg::AMP_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            enm_pkg::REG_PHASE_INC: prdata = r_phase_inc;
            enm_pkg::REG_INV_LEN:   prdata = 32'(r_inv_len);
            enm_pkg::REG_AMPLITUDE: prdata = 32'(r_amplitude);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    enm_pkg::t_state r_state, n_state;

    logic w_in_accept;
    logic w_out_free;
    logic w_commit;

    assign o_ready     = (r_state == enm_pkg::ST_IDLE);
    assign w_in_accept = i_valid && o_ready;
    // Output register frees up in the same cycle its transaction completes
    assign w_out_free  = !o_valid || i_ready;
    assign w_commit    = (r_state == enm_pkg::ST_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= enm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            enm_pkg::ST_IDLE:  if (w_in_accept) n_state = enm_pkg::ST_INDEX;
            enm_pkg::ST_INDEX: n_state = enm_pkg::ST_FRAC;
            enm_pkg::ST_FRAC:  n_state = enm_pkg::ST_ENV;
            enm_pkg::ST_ENV:   n_state = enm_pkg::ST_SCALE;
            enm_pkg::ST_SCALE: n_state = enm_pkg::ST_AMP;
            enm_pkg::ST_AMP:   n_state = enm_pkg::ST_DONE;
            enm_pkg::ST_DONE:  if (w_out_free) n_state = enm_pkg::ST_IDLE;
            default:           n_state = enm_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [enm_pkg::PHASE_W-1:0]  r_phase;
    logic [POSITION_WIDTH-1:0]    r_pos;
    logic signed [SW-1:0]         r_existing;
    logic [IDX_W-1:0]             r_idx;
    logic [FRAC_W-1:0]            r_frac;
    logic signed [SW-1:0]         r_sine;
    logic [enm_pkg::ENV_W-1:0]    r_env;
    logic [enm_pkg::MUL_W-1:0]    r_mag1;
    logic [SW-1:0]                r_tone_mag;

    // Shared multiplier: the sequencer steers both operands
    logic [enm_pkg::MUL_W-1:0]    w_mul_a, w_mul_b;
    logic [2*enm_pkg::MUL_W-1:0]  w_prod;

    logic [SW-1:0]                w_t;          // 4 * (f mod 1/4) in Q.16
    logic [SW-2:0]                w_sine_mag;
    logic                         w_above_q1, w_above_half, w_past_end;
    logic [enm_pkg::INV_LEN_W-1:0] w_fall;
    logic [enm_pkg::ENV_W-1:0]    w_env;

    assign w_t        = r_frac[21:6];
    assign w_sine_mag = r_sine[SW-1] ? (SW-1)'(-r_sine) : r_sine[SW-2:0];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            enm_pkg::ST_INDEX: begin
                w_mul_a = r_phase;
                w_mul_b = enm_pkg::MUL_W'(SINE_TABLE_DEPTH);
            end
            enm_pkg::ST_FRAC: begin
                w_mul_a = enm_pkg::MUL_W'(r_pos);
                w_mul_b = enm_pkg::MUL_W'(r_inv_len);
            end
            enm_pkg::ST_ENV: begin
                w_mul_a = enm_pkg::MUL_W'(enm_pkg::ENV_ONE - {1'b0, w_t});
                w_mul_b = enm_pkg::MUL_W'(enm_pkg::ENV_EIGHT_TENTHS);
            end
            enm_pkg::ST_SCALE: begin
                w_mul_a = enm_pkg::MUL_W'(w_sine_mag);
                w_mul_b = enm_pkg::MUL_W'(r_env);
            end
            enm_pkg::ST_AMP: begin
                w_mul_a = r_mag1;
                w_mul_b = enm_pkg::MUL_W'(r_amplitude);
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Piecewise envelope: rise to 1.0, fall to 0.2, then 1 - f (the seam
    // at the half-way point jumps from 0.2 up to 0.5), zero past the end.
    assign w_above_q1   = |r_frac[FRAC_W-1:22];
    assign w_above_half = |r_frac[FRAC_W-1:23];
    assign w_past_end   = |r_frac[FRAC_W-1:24];
    assign w_fall       = 25'h1000000 - {1'b0, r_frac[23:0]};

    always_comb begin
        if (!w_above_q1) begin
            w_env = {1'b0, w_t};
        end else if (!w_above_half) begin
            w_env = enm_pkg::ENV_W'(w_prod[63:16]) + enm_pkg::ENV_TWO_TENTHS;
        end else if (!w_past_end) begin
            w_env = w_fall[24:8];
        end else begin
            w_env = '0;
        end
    end

    // Signed tone and saturating mix
    logic signed [SW:0]   w_tone;
    logic signed [SW+1:0] w_sum;
    logic                 w_sat_hi, w_sat_lo;

    assign w_tone   = r_sine[SW-1] ? -$signed({1'b0, r_tone_mag})
                                   :  $signed({1'b0, r_tone_mag});
    assign w_sum    = {{2{r_existing[SW-1]}}, r_existing} + {w_tone[SW], w_tone};
    assign w_sat_hi = w_sum > $signed({{2{1'b0}}, enm_pkg::SAMPLE_MAX});
    assign w_sat_lo = w_sum < $signed({{2{1'b1}}, enm_pkg::SAMPLE_MIN});

    // Note state: clear on the first sample of a note, advance at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pos   <= '0;
        end else if (w_in_accept && i_first_of_note) begin
            r_phase <= '0;
            r_pos   <= '0;
        end else if (w_commit) begin
            r_phase <= r_phase + r_phase_inc;
            if (r_pos != '1) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // Step results: each product lands in a register of its own
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            enm_pkg::ST_IDLE:  if (w_in_accept) r_existing <= i_existing_sample;
            enm_pkg::ST_INDEX: r_idx <= w_prod[32 +: IDX_W];
            enm_pkg::ST_FRAC: begin
                r_frac <= w_prod[FRAC_W-1:0];
                r_sine <= SINE_ROM[r_idx];
            end
            enm_pkg::ST_ENV:   r_env      <= w_env;
            enm_pkg::ST_SCALE: r_mag1     <= w_prod[enm_pkg::MUL_W-1:0];
            enm_pkg::ST_AMP:   r_tone_mag <= w_prod[31 +: SW];
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_commit) begin
            o_valid <= 1'b1;
        end else if (o_valid && i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            o_clipped <= w_sat_hi || w_sat_lo;
            if (w_sat_hi) begin
                o_mixed_sample <= enm_pkg::SAMPLE_MAX;
            end else if (w_sat_lo) begin
                o_mixed_sample <= enm_pkg::SAMPLE_MIN;
            end else begin
                o_mixed_sample <= w_sum[SW-1:0];
            end
        end
    end

endmodule
